[design/lzsd_pkg.sv]
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants for the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzsd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic       check_ok;
      logic       last;
   } rsp_type;

   // parse phases
   localparam logic [1:0] PH_MAIN  = 2'd0;
   localparam logic [1:0] PH_PTR2  = 2'd1;
   localparam logic [1:0] PH_CHECK = 2'd2;
   localparam logic [1:0] PH_DONE  = 2'd3;

   // result kinds
   localparam logic KIND_DATA    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // register map
   localparam int         CSR_AW          = 3;
   localparam logic [0:0] CSR_IDX_OUT_LEN = 1'b0;

   localparam logic [7:0] SPACE_BYTE   = 8'h20;
   localparam logic [4:0] LEN_BIAS     = 5'd3;
   localparam logic [3:0] FLAG_INDEX_RST = 4'd8;
   localparam logic [2:0] CHK_LAST     = 3'd3;

endpackage

[design/lzss_stream_decompressor.sv]
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS decoder with a history window in a synchronous RAM and a trailing
// 32-bit checksum check.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one compressed byte per beat, in_last on the final byte.
//   rsp channel: decompressed bytes (out_kind 0) and one checksum verdict
//   (out_kind 1); last marks the final beat caused by one req beat.
//   APB port: register 0 at address 0 holds output_length; write only while
//   the block is idle.
// Timing:
//   a literal or a verdict goes into the output register, or into a hold
//   register while the output register is full.
//   a pointer of length L (3..18) holds req_ready low while it is copied:
//   the window RAM gives one read and one write per cycle, the copied bytes
//   come one per cycle while rsp is not stalled; overlapping copies are
//   served by forwarding the byte written in the same cycle.
// Reset clears all stream state and output_length; the window needs no
//   clearing pass since bytes ahead of the output read as spaces.
// A stalled rsp holds the copy pipeline; a req beat is still accepted while
//   one result waits in the output register.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor
   import lzsd_pkg::*;
#(
   parameter int WINDOW_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   localparam int WIN_AW = $clog2(WINDOW_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;
   localparam logic [1:0] ST_COPY = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] length_ff;
   logic [31:0] count_ff;
   logic [31:0] sum_ff;
   logic        wrapped_ff;
   logic [7:0]  flag_bits_ff;
   logic [3:0]  flag_idx_ff;
   logic [1:0]  phase_ff;
   logic [7:0]  ptr_low_ff;
   logic [31:0] chk_ff;
   logic [2:0]  chk_seen_ff;

   rsp_type     hold_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [4:0]  len_left_ff;
   logic [11:0] off_ff;
   logic [31:0] copy_cnt_ff;
   logic        copy_wrap_ff;
   logic        b_valid_ff, b_valid_in;
   logic        b_space_ff;
   logic        b_fwd_ff;
   logic [7:0]  b_fwd_data_ff;
   logic        b_last_ff;
   logic [7:0]  mem_rd_ff;

   logic [7:0]  window_mem [WINDOW_DEPTH];

   logic        accept, fin, slot_free, reached;
   logic [1:0]  phase_eff;
   logic [31:0] chk_next;
   logic        do_verdict, verdict_ok, go_done, do_chk;
   logic        do_literal, do_flag, do_ptr1, do_ptr2;
   logic        b_adv, issue, a_space, fwd;
   logic [WIN_AW-1:0] rd_addr, wr_addr;
   logic [7:0]  b_value, wr_data;
   logic        emit_en, acc_res_valid, load_rsp;
   rsp_type     acc_res;
   logic        csr_wr;

   // ------------------------------------------------------------------ csr
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[CSR_AW-1:2] == CSR_IDX_OUT_LEN);
   assign prdata = (paddr[CSR_AW-1:2] == CSR_IDX_OUT_LEN) ? length_ff : 32'd0;

   // ------------------------------------------------------------------ decode
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign fin       = req_data.in_last;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign reached   = wrapped_ff || (count_ff >= length_ff);
   assign phase_eff = (phase_ff == PH_MAIN && reached) ? PH_CHECK : phase_ff;
   assign chk_next  = chk_ff | ({24'd0, req_data.in_byte} << {chk_seen_ff[1:0], 3'b000});

   always_comb begin
      do_verdict = 1'b0;
      verdict_ok = 1'b0;
      go_done    = 1'b0;
      do_chk     = 1'b0;
      do_literal = 1'b0;
      do_flag    = 1'b0;
      do_ptr1    = 1'b0;
      do_ptr2    = 1'b0;
      if (accept) begin
         unique case (phase_eff) inside
            PH_DONE: begin
            end
            PH_CHECK: begin
               do_chk = 1'b1;
               if (chk_seen_ff == CHK_LAST) begin
                  do_verdict = 1'b1;
                  verdict_ok = (chk_next == sum_ff);
                  go_done    = 1'b1;
               end else if (fin) begin
                  do_verdict = 1'b1;
               end
            end
            PH_MAIN, PH_PTR2: begin
               if (fin) begin
                  do_verdict = 1'b1;
               end else if (phase_eff == PH_PTR2) begin
                  do_ptr2 = 1'b1;
               end else if (flag_idx_ff[3]) begin
                  do_flag = 1'b1;
               end else if (flag_bits_ff[flag_idx_ff[2:0]]) begin
                  do_literal = 1'b1;
               end else begin
                  do_ptr1 = 1'b1;
               end
            end
         endcase
      end
   end

   // ------------------------------------------------------------------ copy pipe
   assign b_adv   = b_valid_ff && slot_free;
   assign issue   = (state_ff == ST_COPY) && (len_left_ff != 5'd0) && (!b_valid_ff || slot_free);
   assign rd_addr = copy_cnt_ff[WIN_AW-1:0] - WIN_AW'(off_ff);
   assign wr_addr = count_ff[WIN_AW-1:0];
   assign a_space = (off_ff == 12'd0) || (!copy_wrap_ff && ({20'd0, off_ff} > copy_cnt_ff));
   assign b_value = b_space_ff ? SPACE_BYTE : (b_fwd_ff ? b_fwd_data_ff : mem_rd_ff);
   assign fwd     = b_adv && (rd_addr == wr_addr);

   assign emit_en = do_literal || b_adv;
   assign wr_data = do_literal ? req_data.in_byte : b_value;

   always_ff @(posedge clock) begin
      if (emit_en) begin
         window_mem[wr_addr] <= wr_data;
      end
      if (issue) begin
         mem_rd_ff <= window_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------------ results
   assign acc_res_valid = do_literal || do_verdict;
   always_comb begin
      acc_res.out_kind = do_literal ? KIND_DATA : KIND_VERDICT;
      acc_res.out_byte = do_literal ? req_data.in_byte : 8'd0;
      acc_res.check_ok = verdict_ok;
      acc_res.last     = 1'b1;
   end

   always_comb begin
      load_rsp = 1'b0;
      rsp_in   = acc_res;
      if (b_adv) begin
         load_rsp        = 1'b1;
         rsp_in.out_kind = KIND_DATA;
         rsp_in.out_byte = b_value;
         rsp_in.check_ok = 1'b0;
         rsp_in.last     = b_last_ff;
      end else if (state_ff == ST_EMIT) begin
         load_rsp = slot_free;
         rsp_in   = hold_ff;
      end else if (acc_res_valid) begin
         load_rsp = slot_free;
      end
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_res_valid && !slot_free) begin
               state_in = ST_EMIT;
            end else if (do_ptr2) begin
               state_in = ST_COPY;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            if (len_left_ff == 5'd0 && (!b_valid_ff || b_adv)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign b_valid_in = issue ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);

   // ------------------------------------------------------------------ control regs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         b_valid_ff   <= 1'b0;
         len_left_ff  <= 5'd0;
         length_ff    <= 32'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         b_valid_ff   <= b_valid_in;
         if (csr_wr) begin
            length_ff <= pwdata;
         end
         if (do_ptr2) begin
            len_left_ff <= 5'(req_data.in_byte[3:0]) + LEN_BIAS;
         end else if (issue) begin
            len_left_ff <= len_left_ff - 5'd1;
         end
      end
   end

   // stream state
   always_ff @(posedge clock) begin
      if (reset || (accept && fin)) begin
         count_ff     <= 32'd0;
         sum_ff       <= 32'd0;
         wrapped_ff   <= 1'b0;
         flag_bits_ff <= 8'd0;
         flag_idx_ff  <= FLAG_INDEX_RST;
         phase_ff     <= PH_MAIN;
         ptr_low_ff   <= 8'd0;
         chk_ff       <= 32'd0;
         chk_seen_ff  <= 3'd0;
      end else begin
         if (emit_en) begin
            count_ff <= count_ff + 32'd1;
            sum_ff   <= sum_ff + {24'd0, wr_data};
            if (count_ff == 32'hffff_ffff) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (accept && phase_eff == PH_CHECK) begin
            phase_ff <= go_done ? PH_DONE : PH_CHECK;
         end
         if (do_chk) begin
            chk_ff      <= chk_next;
            chk_seen_ff <= chk_seen_ff + 3'd1;
         end
         if (do_flag) begin
            flag_bits_ff <= req_data.in_byte;
            flag_idx_ff  <= 4'd0;
         end
         if (do_literal || do_ptr2) begin
            flag_idx_ff <= flag_idx_ff + 4'd1;
         end
         if (do_ptr1) begin
            ptr_low_ff <= req_data.in_byte;
            phase_ff   <= PH_PTR2;
         end
         if (do_ptr2) begin
            phase_ff <= PH_MAIN;
         end
      end
   end

   // ------------------------------------------------------------------ payload regs
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
      if (state_ff == ST_IDLE && acc_res_valid && !slot_free) begin
         hold_ff <= acc_res;
      end
      if (do_ptr2) begin
         off_ff       <= {req_data.in_byte[7:4], ptr_low_ff};
         copy_cnt_ff  <= count_ff;
         copy_wrap_ff <= wrapped_ff;
      end else if (issue) begin
         copy_cnt_ff <= copy_cnt_ff + 32'd1;
         if (copy_cnt_ff == 32'hffff_ffff) begin
            copy_wrap_ff <= 1'b1;
         end
      end
      if (issue) begin
         b_space_ff    <= a_space;
         b_fwd_ff      <= fwd;
         b_fwd_data_ff <= b_value;
         b_last_ff     <= (len_left_ff == 5'd1);
      end
   end

   // ------------------------------------------------------------------ checks
   a_bvalid_in_copy: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |-> state_ff == ST_COPY)
      else $error("copy stage busy outside copy state");

   a_len_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_COPY |-> len_left_ff == 5'd0)
      else $error("copy count left over after copy");

   a_fwd_taken: assert property (@(posedge clock) disable iff (reset)
      issue && b_adv && rd_addr == wr_addr |=> b_fwd_ff && b_valid_ff)
      else $error("overlapping copy not forwarded");

   a_emit_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> rsp_valid_ff)
      else $error("held result waits with empty output register");

endmodule
